### rtl/power_monitor_code_converter_assert.svh
// assertion macros used by the converter checker
`ifndef POWER_MONITOR_CODE_CONVERTER_ASSERT_SVH
`define POWER_MONITOR_CODE_CONVERTER_ASSERT_SVH

// property checked on every clock edge outside reset
`define PMCC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// property checked on every clock edge, reset included
`define PMCC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### rtl/pmcc_pkg.sv
// types and constants of the power monitor code converter
package pmcc_pkg;

  localparam int unsigned SenseW    = 16;
  localparam int unsigned ValW      = 32;
  localparam int unsigned UnitW     = 34;
  localparam int unsigned DivStages = UnitW;
  localparam int unsigned MulW      = 29;
  localparam int unsigned ProdW     = MulW + SenseW;

  typedef enum logic {
    CmdDecode = 1'b0,
    CmdEncode = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    QtyPower   = 2'd0,
    QtyCurrent = 2'd1,
    QtySupply  = 2'd2,
    QtyAux     = 2'd3
  } qty_e;

  typedef enum logic {
    RegSense   = 1'b0,
    RegMultSel = 1'b1
  } reg_e;

  localparam logic [SenseW-1:0] SenseReset = 16'd1;
  localparam logic [9:0]        Scale625   = 10'd625;
  localparam logic [4:0]        Scale25    = 5'd25;
  localparam logic [8:0]        RoundPwr   = 9'd312;
  localparam logic [3:0]        RoundCur   = 4'd12;
  localparam logic [23:0]       PowerMax   = 24'hFFFFFF;
  localparam logic [11:0]       ShortMax   = 12'hFFF;
  localparam logic [1:0]        BytesPower = 2'd3;
  localparam logic [1:0]        BytesShort = 2'd2;

  typedef struct packed {
    logic            command;
    logic [1:0]      quantity;
    logic [7:0]      raw_hi;
    logic [7:0]      raw_mid;
    logic [7:0]      raw_lo;
    logic [ValW-1:0] unit_value;
  } in_req_t;

  typedef struct packed {
    logic [UnitW-1:0] unit_result;
    logic [7:0]       code_hi;
    logic [7:0]       code_mid;
    logic [7:0]       code_lo;
    logic [1:0]       byte_count;
    logic             saturated;
  } out_rsp_t;

  typedef struct packed {
    logic       command;
    logic [1:0] quantity;
  } meta_t;

endpackage

### rtl/power_monitor_code_converter.sv
// power monitor code converter top level
// Converts power monitor register codes to microwatts, milliamps and millivolts and back.
// One request per cycle is taken while in_stall_o is low, and one response comes out
// for each, in order, through these registers: scaling, rounding offset, a pipelined
// restoring divider (one quotient bit per stage, shared by the sense resistance division
// on decode and the divisions by 625 and 25 on encode), sense resistance multiply, and
// the output register. A single skid entry behind the output register takes the response
// that arrives while the output stalls; in_stall_o rises only once that entry is full.
// The user must write configuration only while no request is in flight; the block itself
// does not enforce this.
module power_monitor_code_converter import pmcc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_index_i,
  input  logic [SenseW-1:0] cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_req_t           in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_rsp_t          out_rsp_o
);

  // configuration registers
  logic [SenseW-1:0] sense_q;
  logic              mult_sel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sense_q    <= SenseReset;
      mult_sel_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_index_i))
        RegSense:   sense_q    <= cfg_data_i;
        RegMultSel: mult_sel_q <= cfg_data_i[0];
        default:    sense_q    <= sense_q;
      endcase
    end
  end

  // a sense value of zero or one means no scaling by the resistor
  logic              sense_big;
  logic [SenseW-1:0] sense_eff;
  assign sense_big = |sense_q[SenseW-1:1];
  assign sense_eff = sense_big ? sense_q : SenseW'(1);

  // whole pipeline advances unless the skid entry is occupied
  logic en;
  logic skid_valid_q;
  assign en         = ~skid_valid_q;
  assign in_stall_o = skid_valid_q;

  // ---------------------------------------------------------------------------
  // stage p1: unpack and scale, pick divisor and rounding offset
  // ---------------------------------------------------------------------------
  logic [23:0]       code_pwr;
  logic [11:0]       code_sht;
  logic [UnitW-1:0]  p1_x_d;
  logic [SenseW-1:0] p1_div_d;
  logic [SenseW-2:0] p1_rnd_d;

  assign code_pwr = {in_req_i.raw_hi, in_req_i.raw_mid, in_req_i.raw_lo};
  assign code_sht = {in_req_i.raw_hi, in_req_i.raw_mid[7:4]};

  always_comb begin
    p1_x_d   = '0;
    p1_div_d = SenseW'(1);
    p1_rnd_d = '0;
    if (cmd_e'(in_req_i.command) == CmdDecode) begin
      unique case (qty_e'(in_req_i.quantity))
        QtyPower: begin
          if (mult_sel_q) begin
            p1_x_d = UnitW'(code_pwr) * UnitW'(Scale625);
          end else begin
            p1_x_d = (UnitW'(code_pwr) * UnitW'(Scale25)) >> 1;
          end
          if (sense_big) begin
            p1_div_d = sense_q;
            p1_rnd_d = sense_q[SenseW-1:1];
          end
        end
        QtyCurrent: begin
          p1_x_d = UnitW'(code_sht) * UnitW'(Scale25);
          if (sense_big) begin
            p1_div_d = sense_q;
            p1_rnd_d = sense_q[SenseW-1:1];
          end
        end
        QtySupply: p1_x_d = UnitW'(code_sht) * UnitW'(Scale25);
        QtyAux:    p1_x_d = UnitW'(code_sht >> 1);
        default:   p1_x_d = '0;
      endcase
    end else begin
      unique case (qty_e'(in_req_i.quantity))
        QtyPower: begin
          if (mult_sel_q) begin
            p1_x_d   = UnitW'(in_req_i.unit_value) + UnitW'(RoundPwr);
            p1_div_d = SenseW'(Scale625);
          end else begin
            p1_x_d   = UnitW'(in_req_i.unit_value) + UnitW'(RoundCur);
            p1_div_d = SenseW'(Scale25);
          end
        end
        QtyCurrent: begin
          p1_x_d   = UnitW'(in_req_i.unit_value) + UnitW'(RoundCur);
          p1_div_d = SenseW'(Scale25);
        end
        QtySupply: begin
          p1_x_d   = UnitW'(in_req_i.unit_value);
          p1_div_d = SenseW'(Scale25);
        end
        QtyAux:  p1_x_d = UnitW'(in_req_i.unit_value) << 1;
        default: p1_x_d = '0;
      endcase
    end
  end

  logic              p1_valid_q;
  meta_t             p1_meta_q;
  logic [UnitW-1:0]  p1_x_q;
  logic [SenseW-1:0] p1_div_q;
  logic [SenseW-2:0] p1_rnd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
    end else if (en) begin
      p1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_meta_q <= '{command: in_req_i.command, quantity: in_req_i.quantity};
      p1_x_q    <= p1_x_d;
      p1_div_q  <= p1_div_d;
      p1_rnd_q  <= p1_rnd_d;
    end
  end

  // ---------------------------------------------------------------------------
  // stage p2: add rounding offset to form the dividend
  // ---------------------------------------------------------------------------
  logic              p2_valid_q;
  meta_t             p2_meta_q;
  logic [UnitW-1:0]  p2_num_q;
  logic [SenseW-1:0] p2_div_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_valid_q <= 1'b0;
    end else if (en) begin
      p2_valid_q <= p1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p2_meta_q <= p1_meta_q;
      p2_num_q  <= p1_x_q + UnitW'(p1_rnd_q);
      p2_div_q  <= p1_div_q;
    end
  end

  // ---------------------------------------------------------------------------
  // divider: one restoring step per stage, dividend bits shift out the top and
  // quotient bits shift in at the bottom
  // ---------------------------------------------------------------------------
  logic              dv_valid_q [DivStages];
  meta_t             dv_meta_q  [DivStages];
  logic [UnitW-1:0]  dv_dq_q    [DivStages];
  logic [SenseW-1:0] dv_rem_q   [DivStages-1];
  logic [SenseW-1:0] dv_div_q   [DivStages-1];

  for (genvar i = 0; i < DivStages; i++) begin : g_div
    logic              src_valid;
    meta_t             src_meta;
    logic [UnitW-1:0]  src_dq;
    logic [SenseW-1:0] src_rem;
    logic [SenseW-1:0] src_div;
    logic [SenseW:0]   rem_sh;
    logic              ge;

    if (i == 0) begin : g_first
      assign src_valid = p2_valid_q;
      assign src_meta  = p2_meta_q;
      assign src_dq    = p2_num_q;
      assign src_rem   = '0;
      assign src_div   = p2_div_q;
    end else begin : g_next
      assign src_valid = dv_valid_q[i-1];
      assign src_meta  = dv_meta_q[i-1];
      assign src_dq    = dv_dq_q[i-1];
      assign src_rem   = dv_rem_q[i-1];
      assign src_div   = dv_div_q[i-1];
    end

    assign rem_sh = {src_rem, src_dq[UnitW-1]};
    assign ge     = rem_sh >= {1'b0, src_div};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_valid_q[i] <= 1'b0;
      end else if (en) begin
        dv_valid_q[i] <= src_valid;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_meta_q[i] <= src_meta;
        dv_dq_q[i]   <= {src_dq[UnitW-2:0], ge};
      end
    end

    // last step needs neither remainder nor divisor afterwards
    if (i < DivStages - 1) begin : g_keep
      always_ff @(posedge clk_i) begin
        if (en) begin
          dv_rem_q[i] <= ge ? SenseW'(rem_sh - {1'b0, src_div}) : rem_sh[SenseW-1:0];
          dv_div_q[i] <= src_div;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage m: encode power and current get the sense resistance multiply
  // ---------------------------------------------------------------------------
  logic [UnitW-1:0] quo;
  meta_t            quo_meta;
  logic             mul_case;
  logic [MulW-1:0]  mul_op;

  assign quo      = dv_dq_q[DivStages-1];
  assign quo_meta = dv_meta_q[DivStages-1];
  assign mul_case = (cmd_e'(quo_meta.command) == CmdEncode)
                    && ((qty_e'(quo_meta.quantity) == QtyPower)
                    || (qty_e'(quo_meta.quantity) == QtyCurrent));
  // auxiliary-source power code counts in steps of two
  assign mul_op   = ((qty_e'(quo_meta.quantity) == QtyPower) && !mult_sel_q)
                    ? {quo[MulW-2:0], 1'b0} : quo[MulW-1:0];

  logic             m_valid_q;
  meta_t            m_meta_q;
  logic [ProdW-1:0] m_val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (en) begin
      m_valid_q <= dv_valid_q[DivStages-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_meta_q <= quo_meta;
      m_val_q  <= mul_case ? ProdW'(mul_op) * ProdW'(sense_eff) : ProdW'(quo);
    end
  end

  // ---------------------------------------------------------------------------
  // clamp and pack into the response
  // ---------------------------------------------------------------------------
  out_rsp_t   pack_rsp;
  logic [23:0] code24;
  logic [11:0] code12;

  always_comb begin
    pack_rsp = '0;
    code24   = '0;
    code12   = '0;
    pack_rsp.byte_count = (qty_e'(m_meta_q.quantity) == QtyPower) ? BytesPower : BytesShort;
    if (cmd_e'(m_meta_q.command) == CmdDecode) begin
      pack_rsp.unit_result = m_val_q[UnitW-1:0];
    end else if (qty_e'(m_meta_q.quantity) == QtyPower) begin
      pack_rsp.saturated = m_val_q > ProdW'(PowerMax);
      code24             = pack_rsp.saturated ? PowerMax : m_val_q[23:0];
      pack_rsp.code_hi   = code24[23:16];
      pack_rsp.code_mid  = code24[15:8];
      pack_rsp.code_lo   = code24[7:0];
    end else begin
      pack_rsp.saturated = m_val_q > ProdW'(ShortMax);
      code12             = pack_rsp.saturated ? ShortMax : m_val_q[11:0];
      pack_rsp.code_hi   = code12[11:4];
      pack_rsp.code_mid  = {code12[3:0], 4'b0000};
    end
  end

  // ---------------------------------------------------------------------------
  // output register with one skid entry
  // ---------------------------------------------------------------------------
  logic     out_valid_q;
  out_rsp_t out_rsp_q;
  out_rsp_t skid_rsp_q;
  logic     out_held;

  assign out_held = out_valid_q & out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (en) begin
      if (out_held) begin
        skid_valid_q <= m_valid_q;
      end else begin
        out_valid_q <= m_valid_q;
      end
    end else if (!out_held) begin
      // skid entry moves up into the freed output register
      out_valid_q  <= 1'b1;
      skid_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (out_held) begin
        skid_rsp_q <= pack_rsp;
      end else begin
        out_rsp_q <= pack_rsp;
      end
    end else if (!out_held) begin
      out_rsp_q <= skid_rsp_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

### rtl/pmcc_checker.sv
// port-level assertions for the power monitor code converter
`include "power_monitor_code_converter_assert.svh"

module pmcc_checker import pmcc_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input out_rsp_t out_rsp_o
);

  // nothing valid or stalled in the cycle after reset is sampled low
  `PMCC_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> (!out_valid_o && !in_stall_o), "active in reset")

  // a stalled response stays offered
  `PMCC_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o, "response dropped")

  // input side stalls only after the output was stalled
  `PMCC_ASSERT(a_stall_cause, $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i),
               "input stalled without output stall")

  // a clamped power code is all ones
  `PMCC_ASSERT(a_sat_power,
               out_valid_o && out_rsp_o.saturated && out_rsp_o.byte_count == BytesPower
               |-> (out_rsp_o.code_hi == 8'hFF && out_rsp_o.code_mid == 8'hFF
                    && out_rsp_o.code_lo == 8'hFF),
               "bad clamped power code")

  // two-byte responses never carry a third byte
  `PMCC_ASSERT(a_short_lo,
               out_valid_o && out_rsp_o.byte_count != BytesPower
               |-> (out_rsp_o.byte_count == BytesShort && out_rsp_o.code_lo == 8'h00),
               "bad short response")

endmodule

bind power_monitor_code_converter pmcc_checker u_pmcc_checker (.*);

### tb/sv/testbench.sv
// self-checking testbench for the power monitor code converter
`timescale 1ns / 1ps

module testbench import pmcc_pkg::*; ();

  // number of register settings the run walks through, random requests per setting
  localparam int NumSettings  = 9;
  localparam int RandPerPhase = 185;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_we_i    = 1'b0;
  logic              cfg_index_i = 1'b0;
  logic [SenseW-1:0] cfg_data_i  = '0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  in_req_t           in_req_i    = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  out_rsp_t          out_rsp_o;

  // requests waiting to be presented, and the responses they must produce, in order
  in_req_t  requests_to_send [$];
  out_rsp_t conversions_due [$];

  // testbench copy of the two registers
  logic [SenseW-1:0] sense_copy = SenseReset;
  logic              mult_copy  = 1'b0;

  // idle percentages for the two sides, changed between phases
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  int unsigned errors      = 0;
  int unsigned sent_count  = 0;
  int unsigned recv_count  = 0;
  int unsigned sat_count   = 0;

  power_monitor_code_converter u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

  always #5 clk_i = ~clk_i;

  // expected response of one request under the given register values
  function automatic out_rsp_t convert_code(in_req_t req, logic [SenseW-1:0] sense,
                                            logic mult_sel);
    logic [63:0] code;
    logic [63:0] val;
    logic [63:0] res;
    logic [63:0] limit;
    out_rsp_t    rsp;
    val = 64'(req.unit_value);
    res = 64'(sense);
    rsp = '0;
    rsp.byte_count = (req.quantity == QtyPower) ? BytesPower : BytesShort;
    if (req.command == CmdDecode) begin
      // power is a full 24-bit code, the rest are left-aligned 12-bit codes
      if (req.quantity == QtyPower) code = {40'd0, req.raw_hi, req.raw_mid, req.raw_lo};
      else code = {52'd0, req.raw_hi, req.raw_mid[7:4]};
      case (req.quantity)
        QtyPower: begin
          code = mult_sel ? code * 64'd625 : (code * 64'd25) >> 1;
          if (sense > 1) code = (code + res / 2) / res;
        end
        QtyCurrent: begin
          code = code * 64'd25;
          if (sense > 1) code = (code + res / 2) / res;
        end
        QtySupply: code = code * 64'd25;
        default:   code = code >> 1;
      endcase
      rsp.unit_result = code[UnitW-1:0];
    end else begin
      limit = (req.quantity == QtyPower) ? 64'hFF_FFFF : 64'hFFF;
      case (req.quantity)
        QtyPower: begin
          code = mult_sel ? (val + 64'd312) / 64'd625 : ((val + 64'd12) / 64'd25) * 64'd2;
          if (sense > 1) code = code * res;
        end
        QtyCurrent: begin
          code = (val + 64'd12) / 64'd25;
          if (sense > 1) code = code * res;
        end
        QtySupply: code = val / 64'd25;
        default:   code = val * 64'd2;
      endcase
      // clamp to the code width and flag it
      if (code > limit) begin
        code = limit;
        rsp.saturated = 1'b1;
      end
      if (req.quantity == QtyPower) begin
        rsp.code_hi  = code[23:16];
        rsp.code_mid = code[15:8];
        rsp.code_lo  = code[7:0];
      end else begin
        rsp.code_hi  = code[11:4];
        rsp.code_mid = {code[3:0], 4'h0};
      end
    end
    return rsp;
  endfunction

  function automatic in_req_t make_request(cmd_e cmd, qty_e qty, logic [7:0] hi,
                                           logic [7:0] mid, logic [7:0] lo,
                                           logic [ValW-1:0] val);
    in_req_t req;
    req.command    = cmd;
    req.quantity   = qty;
    req.raw_hi     = hi;
    req.raw_mid    = mid;
    req.raw_lo     = lo;
    req.unit_value = val;
    return req;
  endfunction

  // random request: mostly spread over all magnitudes so encodes both fit and clamp
  function automatic in_req_t random_request();
    in_req_t req;
    req.command  = cmd_e'($urandom_range(0, 1));
    req.quantity = qty_e'($urandom_range(0, 3));
    req.raw_hi   = 8'($urandom());
    req.raw_mid  = 8'($urandom());
    req.raw_lo   = 8'($urandom());
    case ($urandom_range(0, 7))
      0, 1, 2: req.unit_value = $urandom();
      7:       req.unit_value = $urandom_range(0, 1) ? '1 : '0;
      default: req.unit_value = $urandom() >> $urandom_range(0, 31);
    endcase
    return req;
  endfunction

  task automatic cfg_write(reg_e idx, logic [SenseW-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    if (idx == RegSense) sense_copy = data;
    else mult_copy = data[0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic check_field(string name, logic [63:0] exp_val, logic [63:0] act_val);
    if (exp_val !== act_val) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_val, act_val);
    end
  endtask

  // driver: presents queued requests, keeps a stalled request steady, idles at random
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      // request taken at this edge: predict its response now
      if (in_valid_i && !in_stall_o) begin
        conversions_due.push_back(convert_code(in_req_i, sense_copy, mult_copy));
        if (conversions_due[$].saturated) sat_count++;
        sent_count++;
      end
      // only move on once the current request is gone
      if (!in_valid_i || !in_stall_o) begin
        if (requests_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          in_req_i   <= requests_to_send.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each taken response against the oldest prediction, stalls at random
  always @(posedge clk_i) begin
    out_rsp_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        recv_count++;
        if (conversions_due.size() == 0) begin
          errors++;
          $display("%0t: response with none expected, got %h", $time, out_rsp_o);
        end else begin
          want = conversions_due.pop_front();
          check_field("unit_result", 64'(want.unit_result), 64'(out_rsp_o.unit_result));
          check_field("code_hi", 64'(want.code_hi), 64'(out_rsp_o.code_hi));
          check_field("code_mid", 64'(want.code_mid), 64'(out_rsp_o.code_mid));
          check_field("code_lo", 64'(want.code_lo), 64'(out_rsp_o.code_lo));
          check_field("byte_count", 64'(want.byte_count), 64'(out_rsp_o.byte_count));
          check_field("saturated", 64'(want.saturated), 64'(out_rsp_o.saturated));
        end
      end
      out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // safety net against a hung handshake
  initial begin
    #2_000_000;
    $display("timeout with %0d responses outstanding", conversions_due.size());
    $display("testbench: errors");
    $finish;
  end

  // stimulus and phase control
  initial begin
    logic [SenseW-1:0] sense_plan [NumSettings];
    logic              mult_plan  [NumSettings];
    // phase 0 keeps the reset values; the rest hit the extremes and a few random points
    sense_plan = '{16'd1, 16'hFFFF, 16'd0, 16'd2, 16'd3, 16'd0, 16'hFFFF, 16'd1, 16'd0};
    mult_plan  = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
    sense_plan[5] = 16'($urandom_range(4, 65534));
    sense_plan[8] = 16'($urandom_range(4, 1000));
    mult_plan[8]  = 1'($urandom_range(0, 1));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int ph = 0; ph < NumSettings; ph++) begin
      // sender idles lightly then heavily, receiver the other way round, then no gaps
      case (ph / 3)
        0:       begin send_idle_pct = 13; recv_idle_pct = 53; end
        1:       begin send_idle_pct = 53; recv_idle_pct = 13; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase

      if (ph != 0) begin
        cfg_write(RegSense, sense_plan[ph]);
        cfg_write(RegMultSel, {15'd0, mult_plan[ph]});
      end

      if (ph == 0) begin
        // decode: full and empty codes, ignored low nibble and unused low byte
        requests_to_send.push_back(make_request(CmdDecode, QtyPower, 8'hFF, 8'hFF, 8'hFF, '0));
        requests_to_send.push_back(make_request(CmdDecode, QtyPower, 8'h00, 8'h00, 8'h00, '1));
        requests_to_send.push_back(make_request(CmdDecode, QtyPower, 8'h00, 8'h00, 8'h01, '0));
        requests_to_send.push_back(make_request(CmdDecode, QtyCurrent, 8'hFF, 8'hFF, 8'hAA, '0));
        requests_to_send.push_back(make_request(CmdDecode, QtyCurrent, 8'h00, 8'h0F, 8'hFF, '0));
        requests_to_send.push_back(make_request(CmdDecode, QtySupply, 8'hFF, 8'hF0, 8'h00, '0));
        requests_to_send.push_back(make_request(CmdDecode, QtySupply, 8'h12, 8'h3F, 8'h55, '0));
        requests_to_send.push_back(make_request(CmdDecode, QtyAux, 8'hFF, 8'hFF, 8'hFF, '0));
        requests_to_send.push_back(make_request(CmdDecode, QtyAux, 8'h00, 8'h10, 8'h00, '0));
        // encode: zero, full scale, rounding edges and the clamp boundaries
        requests_to_send.push_back(make_request(CmdEncode, QtyPower, '1, '1, '1, 32'd0));
        requests_to_send.push_back(make_request(CmdEncode, QtyPower, '0, '0, '0, '1));
        requests_to_send.push_back(make_request(CmdEncode, QtyPower, '0, '0, '0, 32'd312));
        requests_to_send.push_back(make_request(CmdEncode, QtyCurrent, '0, '0, '0, 32'd12));
        requests_to_send.push_back(make_request(CmdEncode, QtyCurrent, '0, '0, '0, 32'd13));
        requests_to_send.push_back(make_request(CmdEncode, QtyCurrent, '0, '0, '0, '1));
        requests_to_send.push_back(make_request(CmdEncode, QtySupply, '0, '0, '0, 32'd24));
        requests_to_send.push_back(make_request(CmdEncode, QtySupply, '0, '0, '0, 32'd102399));
        requests_to_send.push_back(make_request(CmdEncode, QtySupply, '0, '0, '0, 32'd102400));
        requests_to_send.push_back(make_request(CmdEncode, QtySupply, '0, '0, '0, '1));
        requests_to_send.push_back(make_request(CmdEncode, QtyAux, '0, '0, '0, 32'd2047));
        requests_to_send.push_back(make_request(CmdEncode, QtyAux, '0, '0, '0, 32'd2048));
        requests_to_send.push_back(make_request(CmdEncode, QtyAux, '0, '0, '0, '1));
      end

      repeat (RandPerPhase) requests_to_send.push_back(random_request());

      // drain fully before the registers may change
      do @(negedge clk_i);
      while (requests_to_send.size() != 0 || in_valid_i || conversions_due.size() != 0);
    end

    // let any stray response show up past the pipeline depth
    repeat (60) @(posedge clk_i);

    $display("%0d requests sent, %0d responses checked, %0d encodes clamped",
             sent_count, recv_count, sat_count);
    $display("%0d register settings, sense resistance 0 to 65535, both multiplier sources",
             NumSettings);
    if (errors == 0 && conversions_due.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
